// ===== sv/ekfu_pkg.sv =====
// shared types and constants for the 4-state, 3-measurement kalman update
// no dependencies
package ekfu_pkg;

   localparam int DATA_W = 32;
   localparam int ACC_W  = 64;

   // operand selector codes of a load word
   localparam logic [2:0] SEL_F = 3'd0;
   localparam logic [2:0] SEL_H = 3'd1;
   localparam logic [2:0] SEL_Q = 3'd2;
   localparam logic [2:0] SEL_R = 3'd3;
   localparam logic [2:0] SEL_Z = 3'd4;
   localparam logic [2:0] SEL_PH = 3'd5;
   localparam logic [2:0] SEL_X = 3'd6;

   // computation steps of one update
   typedef enum logic [3:0] {
      PH_PP, PH_PHT, PH_S, PH_CO, PH_DET, PH_Y, PH_K, PH_X, PH_A, PH_COV
   } ekfu_phase_type;

   typedef struct packed {
      logic                     req_type;
      logic [2:0]               matrix_select;
      logic [3:0]               element_index;
      logic signed [DATA_W-1:0] element_value;
   } ekfu_req_word_type;

   typedef struct packed {
      logic [1:0]               state_index;
      logic signed [DATA_W-1:0] state_value;
      logic                     last_result;
      logic                     singular;
   } ekfu_rsp_word_type;

   typedef struct packed {
      logic           load;
      logic           init;
      logic           mul;
      logic           store;
      logic           div_start;
      logic           emit;
      ekfu_phase_type phase;
      logic [1:0]     row;
      logic [1:0]     col;
      logic [2:0]     term;
   } ekfu_cmd_type;

   typedef struct packed {
      logic singular;
      logic div_done;
   } ekfu_status_type;

endpackage

// ===== sv/ekfu_div.sv =====
// restoring divider: saturated (num * 2^frac) / den, one quotient bit per cycle
// depends on ekfu_pkg
module ekfu_div import ekfu_pkg::*; #(
   parameter int FRAC_BITS = 24
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [DATA_W-1:0] num,
   input  logic signed [DATA_W-1:0] den,
   output logic                     done,
   output logic signed [DATA_W-1:0] quot
);

   localparam int DIVD_W = DATA_W + FRAC_BITS;
   localparam int CNT_W  = $clog2(DIVD_W + 1);
   localparam logic [DATA_W-1:0] DMAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] DMIN = {1'b1, {(DATA_W-1){1'b0}}};

   logic              run_ff, done_ff, neg_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [DATA_W-1:0] den_ff, rem_ff;
   logic [DIVD_W-1:0] dvd_ff, quo_ff;
   logic [DATA_W-1:0] quot_ff;

   logic [DATA_W:0]   r_sh, r_nx;
   logic              fit;
   logic [DIVD_W-1:0] q_nx;
   logic [DATA_W-1:0] num_mag, den_mag, sat_q;
   logic              over_pos, over_neg;

   always_comb begin
      num_mag = num[DATA_W-1] ? DATA_W'(-num) : DATA_W'(num);
      den_mag = den[DATA_W-1] ? DATA_W'(-den) : DATA_W'(den);
      r_sh = {rem_ff, dvd_ff[DIVD_W-1]};
      fit  = r_sh >= {1'b0, den_ff};
      r_nx = fit ? (r_sh - {1'b0, den_ff}) : r_sh;
      q_nx = {quo_ff[DIVD_W-2:0], fit};
      over_pos = |q_nx[DIVD_W-1:DATA_W-1];
      over_neg = (|q_nx[DIVD_W-1:DATA_W]) || (q_nx[DATA_W-1] && (|q_nx[DATA_W-2:0]));
      if (neg_ff) begin
         sat_q = over_neg ? DMIN : (DATA_W'(0) - q_nx[DATA_W-1:0]);
      end else begin
         sat_q = over_pos ? DMAX : q_nx[DATA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= CNT_W'(DIVD_W);
         end else if (run_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff <= num[DATA_W-1] ^ den[DATA_W-1];
         den_ff <= den_mag;
         rem_ff <= '0;
         dvd_ff <= {num_mag, {FRAC_BITS{1'b0}}};
         quo_ff <= '0;
      end else if (run_ff) begin
         rem_ff <= r_nx[DATA_W-1:0];
         dvd_ff <= {dvd_ff[DIVD_W-2:0], 1'b0};
         quo_ff <= q_nx;
         if (cnt_ff == CNT_W'(1)) begin
            quot_ff <= sat_q;
         end
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

// ===== sv/ekfu_ctrl.sv =====
// sequencer: walks the update element by element and drives datapath commands
// depends on ekfu_pkg
module ekfu_ctrl import ekfu_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic            run_req,
   input  ekfu_status_type status,
   output logic            busy,
   output ekfu_cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_IDLE, S_INIT, S_MUL, S_DRAIN, S_STORE, S_DIV, S_EMIT
   } state_type;

   state_type      state_ff;
   ekfu_phase_type phase_ff;
   logic [1:0]     row_ff, col_ff;
   logic [2:0]     term_ff;
   logic           drain_ff;

   function automatic logic [1:0] rows_last(ekfu_phase_type p);
      case (p)
         PH_S, PH_CO, PH_Y: rows_last = 2'd2;
         PH_DET:            rows_last = 2'd0;
         default:           rows_last = 2'd3;
      endcase
   endfunction

   function automatic logic [1:0] cols_last(ekfu_phase_type p);
      case (p)
         PH_PP, PH_A, PH_COV:       cols_last = 2'd3;
         PH_PHT, PH_S, PH_CO, PH_K: cols_last = 2'd2;
         default:                   cols_last = 2'd0;
      endcase
   endfunction

   function automatic logic [2:0] term_last(ekfu_phase_type p);
      case (p)
         PH_PP:                 term_last = 3'd7;
         PH_PHT, PH_S, PH_COV:  term_last = 3'd3;
         PH_CO:                 term_last = 3'd1;
         default:               term_last = 3'd2;
      endcase
   endfunction

   function automatic ekfu_phase_type next_phase(ekfu_phase_type p);
      unique case (p)
         PH_PP:   next_phase = PH_PHT;
         PH_PHT:  next_phase = PH_S;
         PH_S:    next_phase = PH_CO;
         PH_CO:   next_phase = PH_DET;
         PH_DET:  next_phase = PH_Y;
         PH_Y:    next_phase = PH_K;
         PH_K:    next_phase = PH_X;
         PH_X:    next_phase = PH_A;
         PH_A:    next_phase = PH_COV;
         default: next_phase = PH_COV;
      endcase
   endfunction

   logic div_case;

   always_comb begin
      div_case      = (phase_ff == PH_K) && !status.singular;
      cmd.load      = (state_ff == S_IDLE) && start;
      cmd.init      = (state_ff == S_INIT);
      cmd.mul       = (state_ff == S_MUL);
      cmd.div_start = (state_ff == S_STORE) && div_case;
      cmd.store     = ((state_ff == S_STORE) && !div_case) ||
                      ((state_ff == S_DIV) && status.div_done);
      cmd.emit      = (state_ff == S_EMIT);
      cmd.phase     = phase_ff;
      cmd.row       = row_ff;
      cmd.col       = col_ff;
      cmd.term      = term_ff;
   end

   assign busy = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= PH_PP;
         row_ff   <= '0;
         col_ff   <= '0;
         term_ff  <= '0;
         drain_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (start && run_req) begin
                  state_ff <= S_INIT;
                  phase_ff <= PH_PP;
                  row_ff   <= '0;
                  col_ff   <= '0;
               end
            end
            S_INIT: begin
               term_ff  <= '0;
               drain_ff <= 1'b0;
               state_ff <= (phase_ff == PH_Y) ? S_STORE : S_MUL;
            end
            S_MUL: begin
               if (term_ff == term_last(phase_ff)) begin
                  state_ff <= S_DRAIN;
               end else begin
                  term_ff <= term_ff + 1'b1;
               end
            end
            S_DRAIN: begin
               drain_ff <= 1'b1;
               if (drain_ff) begin
                  state_ff <= S_STORE;
               end
            end
            S_STORE, S_DIV: begin
               if (cmd.div_start) begin
                  state_ff <= S_DIV;
               end else if (cmd.store) begin
                  state_ff <= S_INIT;
                  if (col_ff == cols_last(phase_ff)) begin
                     col_ff <= '0;
                     if (row_ff == rows_last(phase_ff)) begin
                        row_ff <= '0;
                        if (phase_ff == PH_COV) begin
                           state_ff <= S_EMIT;
                        end else begin
                           phase_ff <= next_phase(phase_ff);
                        end
                     end else begin
                        row_ff <= row_ff + 1'b1;
                     end
                  end else begin
                     col_ff <= col_ff + 1'b1;
                  end
               end
            end
            S_EMIT: begin
               row_ff <= row_ff + 1'b1;
               if (row_ff == 2'd3) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// ===== sv/ekfu_dp.sv =====
// datapath: operand stores, one pipelined multiply-accumulate, divider, result port
// depends on ekfu_pkg and ekfu_div
module ekfu_dp import ekfu_pkg::*; #(
   parameter int FRAC_BITS = 24
) (
   input  logic              clock,
   input  logic              reset,
   input  ekfu_cmd_type      cmd,
   input  ekfu_req_word_type req,
   output ekfu_status_type   status,
   output logic              rsp_strobe,
   output ekfu_rsp_word_type rsp_data
);

   localparam logic signed [DATA_W-1:0] COV_INIT =
      DATA_W'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
   localparam logic signed [ACC_W-1:0] ONE = ACC_W'(64'd1 << FRAC_BITS);
   localparam logic signed [ACC_W-1:0] AMAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] AMIN = {1'b1, {(ACC_W-1){1'b0}}};
   localparam logic signed [DATA_W-1:0] DMAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] DMIN = {1'b1, {(DATA_W-1){1'b0}}};

   function automatic logic signed [DATA_W-1:0] sat_data(logic signed [ACC_W-1:0] v);
      if ((&v[ACC_W-1:DATA_W-1]) || !(|v[ACC_W-1:DATA_W-1])) begin
         sat_data = v[DATA_W-1:0];
      end else begin
         sat_data = v[ACC_W-1] ? DMIN : DMAX;
      end
   endfunction

   function automatic logic signed [ACC_W-1:0] sat_add(logic signed [ACC_W-1:0] a,
                                                       logic signed [ACC_W-1:0] b);
      logic signed [ACC_W:0] s;
      s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
      if (s[ACC_W] != s[ACC_W-1]) begin
         sat_add = s[ACC_W] ? AMIN : AMAX;
      end else begin
         sat_add = s[ACC_W-1:0];
      end
   endfunction

   function automatic logic [3:0] idx3(logic [1:0] r, logic [1:0] c);
      idx3 = ({2'b00, r} << 1) + {2'b00, r} + {2'b00, c};
   endfunction

   function automatic logic [1:0] next3(logic [1:0] v);
      case (v)
         2'd0:    next3 = 2'd1;
         2'd1:    next3 = 2'd2;
         default: next3 = 2'd0;
      endcase
   endfunction

   function automatic logic signed [ACC_W-1:0] ext(logic signed [DATA_W-1:0] v);
      ext = ACC_W'(v);
   endfunction

   // operand stores
   logic signed [DATA_W-1:0] tj_ff [16];
   logic signed [DATA_W-1:0] mj_ff [12];
   logic signed [DATA_W-1:0] pn_ff [16];
   logic signed [DATA_W-1:0] mn_ff [9];
   logic signed [DATA_W-1:0] mv_ff [3];
   logic signed [DATA_W-1:0] pm_ff [3];
   logic signed [DATA_W-1:0] ps_ff [4];
   logic signed [DATA_W-1:0] cov_ff [16];
   // intermediates
   logic signed [DATA_W-1:0] pp_ff [16];
   logic signed [DATA_W-1:0] pht_ff [12];
   logic signed [DATA_W-1:0] sa_ff [9];
   logic signed [DATA_W-1:0] sb_ff [9];
   logic signed [DATA_W-1:0] co_ff [9];
   logic signed [DATA_W-1:0] y_ff [3];
   logic signed [DATA_W-1:0] k_ff [12];
   logic signed [DATA_W-1:0] x_ff [4];
   logic signed [DATA_W-1:0] a_ff [16];
   logic signed [DATA_W-1:0] det_ff;
   logic                     sing_ff;

   // mac pipeline
   logic                     p1_v_ff, p2_v_ff, p1_neg_ff;
   logic [2*DATA_W-1:0]      p1_mag_ff;
   logic signed [ACC_W-1:0]  p2_term_ff, acc_ff;

   logic              rsp_strobe_ff;
   ekfu_rsp_word_type rsp_data_ff;

   logic [3:0] tj_idx, cov_idx, pp_idx, mj_idx, pht_idx, sa_idx, sb_idx, co_idx, k_idx, a_idx;
   logic [1:0] y_idx, r0, r1, c0, c1, tl;
   logic signed [DATA_W-1:0] op_a, op_b, res, a_res, k_res;
   logic [DATA_W-1:0]        mag_a, mag_b;
   logic                     sub;
   logic signed [ACC_W-1:0]  init_val;
   logic [ACC_W-1:0]         shifted;
   logic [3:0]               wr3, wr4;

   logic                     div_done;
   logic signed [DATA_W-1:0] div_quot;

   ekfu_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (res),
      .den   (det_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_comb begin
      tl = cmd.term[1:0];
      r0 = next3(cmd.row);
      r1 = next3(r0);
      c0 = next3(cmd.col);
      c1 = next3(c0);

      tj_idx  = cmd.term[2] ? {cmd.col, tl} : {cmd.row, tl};
      cov_idx = cmd.term[2] ? {cmd.row, tl} : {tl, cmd.col};
      pp_idx  = (cmd.phase == PH_COV) ? {tl, cmd.col} : {cmd.row, tl};
      case (cmd.phase)
         PH_PHT:  mj_idx = {cmd.col, tl};
         PH_S:    mj_idx = {cmd.row, tl};
         default: mj_idx = {tl, cmd.col};
      endcase
      pht_idx = (cmd.phase == PH_S) ? idx3(tl, cmd.col) : idx3(cmd.row, tl);
      sa_idx  = (cmd.phase == PH_DET) ? {2'b00, tl} : idx3(r0, cmd.term[0] ? c1 : c0);
      sb_idx  = idx3(r1, cmd.term[0] ? c0 : c1);
      co_idx  = (cmd.phase == PH_DET) ? {2'b00, tl} : idx3(cmd.col, tl);
      k_idx   = idx3(cmd.row, tl);
      a_idx   = {cmd.row, tl};
      y_idx   = tl;

      case (cmd.phase)
         PH_PP: begin
            op_a = tj_ff[tj_idx];
            op_b = cov_ff[cov_idx];
         end
         PH_PHT: begin
            op_a = pp_ff[pp_idx];
            op_b = mj_ff[mj_idx];
         end
         PH_S: begin
            op_a = pht_ff[pht_idx];
            op_b = mj_ff[mj_idx];
         end
         PH_CO: begin
            op_a = sa_ff[sa_idx];
            op_b = sb_ff[sb_idx];
         end
         PH_DET: begin
            op_a = sa_ff[sa_idx];
            op_b = co_ff[co_idx];
         end
         PH_K: begin
            op_a = pht_ff[pht_idx];
            op_b = co_ff[co_idx];
         end
         PH_X: begin
            op_a = k_ff[k_idx];
            op_b = y_ff[y_idx];
         end
         PH_A: begin
            op_a = k_ff[k_idx];
            op_b = mj_ff[mj_idx];
         end
         PH_COV: begin
            op_a = pp_ff[pp_idx];
            op_b = a_ff[a_idx];
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
      // second cofactor product is subtracted
      sub   = (cmd.phase == PH_CO) && cmd.term[0];
      mag_a = op_a[DATA_W-1] ? DATA_W'(-op_a) : DATA_W'(op_a);
      mag_b = op_b[DATA_W-1] ? DATA_W'(-op_b) : DATA_W'(op_b);

      wr3 = idx3(cmd.row, cmd.col);
      wr4 = {cmd.row, cmd.col};
      case (cmd.phase)
         PH_PP:   init_val = ext(pn_ff[wr4]);
         PH_S:    init_val = ext(mn_ff[wr3]);
         PH_Y:    init_val = ext(mv_ff[cmd.row]) - ext(pm_ff[cmd.row]);
         PH_X:    init_val = ext(ps_ff[cmd.row]);
         default: init_val = '0;
      endcase

      shifted = p1_mag_ff >> FRAC_BITS;
      res     = sat_data(acc_ff);
      a_res   = sat_data(((cmd.row == cmd.col) ? ONE : ACC_W'(0)) - ext(res));
      k_res   = sing_ff ? DATA_W'(0) : div_quot;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_v_ff <= 1'b0;
         p2_v_ff <= 1'b0;
         sing_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         p1_v_ff <= cmd.mul;
         p2_v_ff <= p1_v_ff;
         rsp_strobe_ff <= cmd.emit;
         if (cmd.store && (cmd.phase == PH_DET)) begin
            sing_ff <= (res == '0);
         end
      end
   end

   always_ff @(posedge clock) begin
      p1_mag_ff  <= mag_a * mag_b;
      p1_neg_ff  <= op_a[DATA_W-1] ^ op_b[DATA_W-1] ^ sub;
      p2_term_ff <= p1_neg_ff ? (ACC_W'(0) - shifted) : shifted;
      if (cmd.init) begin
         acc_ff <= init_val;
      end else if (p2_v_ff) begin
         acc_ff <= sat_add(acc_ff, p2_term_ff);
      end
      if (cmd.emit) begin
         rsp_data_ff.state_index <= cmd.row;
         rsp_data_ff.state_value <= x_ff[cmd.row];
         rsp_data_ff.last_result <= (cmd.row == 2'd3);
         rsp_data_ff.singular    <= sing_ff;
      end
   end

   // loaded operands
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         unique case (req.matrix_select)
            SEL_F: tj_ff[req.element_index] <= req.element_value;
            SEL_H: begin
               if (req.element_index < 4'd12) mj_ff[req.element_index] <= req.element_value;
            end
            SEL_Q: pn_ff[req.element_index] <= req.element_value;
            SEL_R: begin
               if (req.element_index < 4'd9) mn_ff[req.element_index] <= req.element_value;
            end
            SEL_Z: begin
               if (req.element_index < 4'd3) mv_ff[req.element_index[1:0]] <= req.element_value;
            end
            SEL_PH: begin
               if (req.element_index < 4'd3) pm_ff[req.element_index[1:0]] <= req.element_value;
            end
            SEL_X: begin
               if (req.element_index < 4'd4) ps_ff[req.element_index[1:0]] <= req.element_value;
            end
            default: ;
         endcase
      end
   end

   // covariance, reset to its diagonal
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int n = 0; n < 16; n++) begin
            cov_ff[n] <= (n % 5 == 0) ? COV_INIT : '0;
         end
      end else if (cmd.store && (cmd.phase == PH_COV)) begin
         cov_ff[wr4] <= res;
      end
   end

   // intermediate results
   always_ff @(posedge clock) begin
      if (cmd.store) begin
         case (cmd.phase)
            PH_PP:  pp_ff[wr4] <= res;
            PH_PHT: pht_ff[wr3] <= res;
            PH_S: begin
               sa_ff[wr3] <= res;
               sb_ff[wr3] <= res;
            end
            PH_CO:  co_ff[wr3] <= res;
            PH_DET: det_ff <= res;
            PH_Y:   y_ff[cmd.row] <= res;
            PH_K:   k_ff[wr3] <= k_res;
            PH_X:   x_ff[cmd.row] <= res;
            PH_A:   a_ff[wr4] <= a_res;
            default: ;
         endcase
      end
   end

   assign status.singular = sing_ff;
   assign status.div_done = div_done;
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_data        = rsp_data_ff;

endmodule

// ===== sv/extended_kalman_update_4x3_top.sv =====
// load word: stored while idle, busy stays low; run word: busy for the whole
// update, paced by the single shared multiply-accumulate and the bit-serial gain
// divider, which is skipped when the determinant is zero
// then four state words on rsp_strobe in consecutive cycles, the last one in the
// first cycle after busy drops; the receiver cannot stall
// synchronous active-high reset: idle, covariance diagonal 0.1, other stores unset
module extended_kalman_update_4x3_top import ekfu_pkg::*; #(
   parameter int FRAC_BITS = 24
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ekfu_req_word_type req_data,
   output logic              rsp_strobe,
   output ekfu_rsp_word_type rsp_data
);

   // command and status between sequencer and datapath
   ekfu_cmd_type    cmd;
   ekfu_status_type status;

   // sequencer per element: init, products, drain, store; PH_Y skips products
   ekfu_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .run_req (req_data.req_type),
      .status  (status),
      .busy    (busy),
      .cmd     (cmd)
   );

   // datapath holds operands, intermediates, mac pipeline and divider
   ekfu_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req        (req_data),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule
